@@ hw/rtl/dcrc8_pkg.sv @@
// dcrc8_pkg: shared types, constants and the crc-8 byte fold function
// used by every module of the datagram crc-8 generator; no dependencies
`default_nettype none

package dcrc8_pkg;

    localparam int unsigned CRC_WIDTH  = 8;
    localparam int unsigned DATA_WIDTH = 8;

    localparam logic [CRC_WIDTH-1:0]  CRC_POLY = 8'h07;
    localparam logic [CRC_WIDTH-1:0]  CRC_INIT = 8'h00;
    localparam logic [DATA_WIDTH-1:0] BIT_LSB  = 8'h01;

    // one input item held in the input stage
    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_byte;
        logic                  last_byte;
    } dcrc8_item_t;

    // handshake between the input stage and the fold stage
    typedef struct packed {
        logic valid;
        logic advance;
    } dcrc8_ctrl_t;

    // fold one byte into the crc, data lsb first against the crc msb
    function automatic logic [CRC_WIDTH-1:0] crc8_fold_byte(
        input logic [CRC_WIDTH-1:0]  crc_in,
        input logic [DATA_WIDTH-1:0] data_in
    );
        logic [CRC_WIDTH-1:0]  c;
        logic [DATA_WIDTH-1:0] d;
        logic                  fb;
        c = crc_in;
        d = data_in;
        for (int k = 0; k < DATA_WIDTH; k++)
        begin
            fb = c[CRC_WIDTH-1] ^ ((d & BIT_LSB) != '0);
            c  = {c[CRC_WIDTH-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/datagram_crc8_generator.sv @@
// datagram_crc8_generator: top level of the running crc-8 generator
// depends on dcrc8_pkg, dcrc8_in_stage and dcrc8_fold
`default_nettype none

// usage
//   input channel: data_valid / data_stall carry one payload byte per item
//   (data_byte) with last_byte set on the final byte of a datagram
//   output channel: crc_valid / crc_stall carry one result per item:
//   crc_value is the crc-8 (poly 0x07, init 0x00, data lsb first) over the
//   datagram bytes so far, crc_final echoes last_byte
//   pipeline: two register stages (input register, then fold into the
//   result register); a result turns valid at the edge that moves its
//   item from the input register into the result register
//   throughput: one item per cycle while crc_stall is low; the byte fold
//   is combinational between the input register and the result register
//   reset: clears both valid bits and the running crc to zero
//   stall: while crc_stall holds a result, the input register keeps one
//   more item and data_stall rises once it is full; nothing is dropped
//   after an item marked last the running crc returns to zero
module datagram_crc8_generator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               data_valid,
    output logic                                    data_stall,
    input  wire logic [dcrc8_pkg::DATA_WIDTH-1:0]   data_byte,
    input  wire logic                               last_byte,
    output logic                                    crc_valid,
    input  wire logic                               crc_stall,
    output logic [dcrc8_pkg::CRC_WIDTH-1:0]         crc_value,
    output logic                                    crc_final
);
    import dcrc8_pkg::*;

    dcrc8_item_t          item_in;
    dcrc8_item_t          item_held;
    dcrc8_ctrl_t          ctrl;
    logic                 out_ready;
    logic [CRC_WIDTH-1:0] folded;

    logic                 crc_valid_reg;
    logic                 crc_valid_next;
    logic [CRC_WIDTH-1:0] crc_value_reg;
    logic                 crc_final_reg;

    assign item_in.data_byte = data_byte;
    assign item_in.last_byte = last_byte;

    // result register free or being emptied this cycle
    assign out_ready = !crc_valid_reg || !crc_stall;

    dcrc8_in_stage u_in_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .data_valid       (data_valid),
        .data_stall       (data_stall),
        .item_in          (item_in),
        .item_out         (item_held),
        .ctrl_out         (ctrl),
        .downstream_ready (out_ready)
    );

    dcrc8_fold u_fold (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_held),
        .advance (ctrl.advance),
        .crc_out (folded)
    );

    // result valid follows items moving out of the input register
    always_comb
    begin
        crc_valid_next = crc_valid_reg;
        if (out_ready)
        begin
            crc_valid_next = ctrl.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_valid_reg <= 1'b0;
        end
        else
        begin
            crc_valid_reg <= crc_valid_next;
        end
    end

    // result payload loads only when an item moves in
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            crc_value_reg <= folded;
            crc_final_reg <= item_held.last_byte;
        end
    end

    assign crc_valid = crc_valid_reg;
    assign crc_value = crc_value_reg;
    assign crc_final = crc_final_reg;

`ifndef SYNTH
    // an item moving out always lands in the result register with its crc
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance |=> crc_valid_reg && (crc_value_reg == $past(folded)))
    else $error("result register did not capture folded crc");

    // the running crc restarts after the last byte of a datagram
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance && item_held.last_byte |=> u_fold.running_crc_reg == CRC_INIT)
    else $error("running crc not cleared after last byte");

    // input stalls only while the input register holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> ctrl.valid && crc_valid_reg && crc_stall)
    else $error("input stalled with free pipeline space");

    // running crc only changes when an item is folded in
    assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.advance |=> $stable(u_fold.running_crc_reg))
    else $error("running crc changed without an item");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/dcrc8_in_stage.sv @@
// dcrc8_in_stage: input register of the crc-8 generator with its valid bit
// depends on dcrc8_pkg
`default_nettype none

module dcrc8_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               data_valid,
    output logic                    data_stall,
    input  wire dcrc8_pkg::dcrc8_item_t item_in,
    output dcrc8_pkg::dcrc8_item_t  item_out,
    output dcrc8_pkg::dcrc8_ctrl_t  ctrl_out,
    input  wire logic               downstream_ready
);
    import dcrc8_pkg::*;

    logic        item_valid_reg;
    logic        item_valid_next;
    dcrc8_item_t item_reg;
    logic        take;
    logic        move;

    // item leaves when the fold stage can take it
    assign move       = item_valid_reg && downstream_ready;
    assign data_stall = item_valid_reg && !downstream_ready;
    assign take       = data_valid && !data_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (move)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

    assign item_out         = item_reg;
    assign ctrl_out.valid   = item_valid_reg;
    assign ctrl_out.advance = move;

endmodule

`default_nettype wire

@@ hw/rtl/dcrc8_fold.sv @@
// dcrc8_fold: running crc register and the combinational byte fold
// depends on dcrc8_pkg
`default_nettype none

module dcrc8_fold (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dcrc8_pkg::dcrc8_item_t            item_in,
    input  wire logic                              advance,
    output logic [dcrc8_pkg::CRC_WIDTH-1:0]        crc_out
);
    import dcrc8_pkg::*;

    logic [CRC_WIDTH-1:0] running_crc_reg;
    logic [CRC_WIDTH-1:0] running_crc_next;
    logic [CRC_WIDTH-1:0] folded;

    assign folded = crc8_fold_byte(running_crc_reg, item_in.data_byte);

    // clear after the last byte of a datagram
    always_comb
    begin
        running_crc_next = running_crc_reg;
        if (advance)
        begin
            running_crc_next = item_in.last_byte ? CRC_INIT : folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= CRC_INIT;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
        end
    end

    assign crc_out = folded;

endmodule

`default_nettype wire

@@ test/datagram_crc8_generator_test.sv @@
// datagram_crc8_generator_test: self-checking testbench for the datagram crc-8 generator
// depends on dcrc8_pkg and datagram_crc8_generator; a directed list of items, then
// random datagrams; each result compared against a typed-in or running predicted crc
`timescale 1ns / 1ps

module datagram_crc8_generator_test;

    import dcrc8_pkg::*;

    // the run stops here whatever happens; the slowest correct run is far below it
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // minimum count of random items after the directed list
    localparam int unsigned RANDOM_ITEMS  = 1700;
    // longest random wait on either side, in cycles
    localparam int unsigned MAX_WAIT      = 13;
    // long receiver hold-off that fills the block and stalls its input
    localparam int unsigned LONG_HOLD     = 200;
    // settle time after the last result
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned DIRECTED_ROWS = 22;

    // one row of the directed list; known marks rows whose crc is typed in
    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        logic                  is_last;
        logic                  known;
        logic [CRC_WIDTH-1:0]  crc;
    } directed_row_t;

    // one expected result
    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc;
        logic                 is_last;
    } crc_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  data_valid;
    logic                  data_stall;
    logic [DATA_WIDTH-1:0] data_byte;
    logic                  last_byte;
    logic                  crc_valid;
    logic                  crc_stall;
    logic [CRC_WIDTH-1:0]  crc_value;
    logic                  crc_final;

    // crc of the bytes of the current datagram accepted so far
    logic [CRC_WIDTH-1:0]  datagram_crc;
    // results still owed by the block, oldest first
    crc_result_t           expected_crc_q[$];
    int unsigned           failures;
    int unsigned           cycle_count;
    int unsigned           items_sent;
    // random waits on both sides; cleared for stretches of full rate
    logic                  idle_on;
    // sender asks the receiver for one long hold-off
    logic                  hold_request;

    // directed items: extremes of the byte, single-byte datagrams,
    // multi-byte datagrams, and clearing of the register after a last byte
    // crc typed in only where it is obvious: zero bytes from a clear register
    // give zero, and a lone 0x01 gives 0x89
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{8'h00, 1'b1, 1'b1, 8'h00},   // single zero byte right after reset
        '{8'h01, 1'b1, 1'b1, 8'h89},   // single byte, lowest bit only
        '{8'hFF, 1'b1, 1'b0, 8'h00},   // single byte, all ones
        '{8'h80, 1'b1, 1'b0, 8'h00},   // single byte, top bit only
        '{8'h00, 1'b0, 1'b1, 8'h00},   // zero bytes keep the register at zero
        '{8'h00, 1'b1, 1'b1, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},   // four-byte datagram
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hAA, 1'b0, 1'b0, 8'h00},
        '{8'h55, 1'b1, 1'b0, 8'h00},
        '{8'h01, 1'b1, 1'b1, 8'h89},   // register cleared by the last byte before
        '{8'hFF, 1'b0, 1'b0, 8'h00},   // run of all-ones bytes
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b1, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00},   // top bit feeds back against the register
        '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h7F, 1'b0, 1'b0, 8'h00},
        '{8'hFE, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b1, 8'h00},   // zero byte after a long datagram
        '{8'h01, 1'b1, 1'b1, 8'h89}
    };

    datagram_crc8_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .crc_valid  (crc_valid),
        .crc_stall  (crc_stall),
        .crc_value  (crc_value),
        .crc_final  (crc_final)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // crc-8 update of one byte: each data bit, lowest first, is set against
    // the register's top bit; a one feeds the polynomial back after the shift
    function automatic logic [CRC_WIDTH-1:0] crc_update(
        input logic [CRC_WIDTH-1:0]  crc_in,
        input logic [DATA_WIDTH-1:0] byte_in
    );
        logic [CRC_WIDTH-1:0] acc;
        logic                 feedback;
        acc = crc_in;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            feedback = acc[CRC_WIDTH-1] ^ byte_in[i];
            acc      = {acc[CRC_WIDTH-2:0], 1'b0} ^ (feedback ? CRC_POLY : '0);
        end
        return acc;
    endfunction

    // offer one byte, hold it until taken, then record the crc it must give
    task automatic offer_byte(
        input logic [DATA_WIDTH-1:0] value,
        input logic                  is_last,
        input logic                  known,
        input logic [CRC_WIDTH-1:0]  known_crc
    );
        int unsigned          gap;
        logic [CRC_WIDTH-1:0] next_crc;
        crc_result_t          entry;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= value;
        last_byte  <= is_last;
        // accepted at the first edge with the input not stalled
        @(posedge clk);
        while (data_stall)
        begin
            @(posedge clk);
        end
        next_crc      = crc_update(datagram_crc, value);
        entry.crc     = known ? known_crc : next_crc;
        entry.is_last = is_last;
        expected_crc_q.push_back(entry);
        // the register clears after the last byte of a datagram
        datagram_crc = is_last ? CRC_INIT : next_crc;
        items_sent++;
    endtask

    // random byte, with all-zeros and all-ones drawn more often
    function automatic logic [DATA_WIDTH-1:0] random_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // sender: reset, directed list, then random datagrams
    initial
    begin
        int unsigned dgram_len;
        bit          hold_done;
        bit          pause_done;
        rst_n        <= 1'b0;
        data_valid   <= 1'b0;
        data_byte    <= '0;
        last_byte    <= 1'b0;
        datagram_crc  = CRC_INIT;
        failures      = 0;
        items_sent    = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            offer_byte(directed_rows[r].data, directed_rows[r].is_last,
                       directed_rows[r].known, directed_rows[r].crc);
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            // mostly short datagrams, now and then a long one
            dgram_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);

            // full-rate stretch on both sides every few hundred items
            idle_on = !((items_sent % 300) >= 240);

            // one long receiver hold-off with the sender still offering items
            if (items_sent >= 400 && !hold_done)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end

            // one pause of the sender until every result has come back
            if (items_sent >= 900 && !pause_done)
            begin
                data_valid <= 1'b0;
                @(posedge clk);
                while (expected_crc_q.size() != 0)
                begin
                    @(posedge clk);
                end
                pause_done = 1'b1;
            end

            for (int b = 0; b < dgram_len; b++)
            begin
                offer_byte(random_byte(), (b == dgram_len - 1), 1'b0, '0);
            end
        end

        // drain: no more items, receiver at full rate
        data_valid <= 1'b0;
        idle_on     = 1'b0;
        @(posedge clk);
        while (expected_crc_q.size() != 0)
        begin
            @(posedge clk);
        end
        // stray results after the last one still count as failures
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
        begin
            $display("** datagram_crc8_generator: PASSED **");
        end
        else
        begin
            $display("** datagram_crc8_generator: FAILED **");
        end
        $finish;
    end

    // receiver: random stall before each result, one long hold-off on request
    initial
    begin
        int unsigned wait_cycles;
        crc_result_t want;
        crc_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                wait_cycles  = LONG_HOLD;
            end
            else
            begin
                wait_cycles = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (wait_cycles != 0)
            begin
                crc_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            crc_stall <= 1'b0;
            // result taken at the first edge with crc_valid high
            @(posedge clk);
            while (!crc_valid)
            begin
                @(posedge clk);
            end
            if (expected_crc_q.size() == 0)
            begin
                failures++;
                $display("%0t: result with no item pending: crc_value %02h crc_final %0b",
                         $time, crc_value, crc_final);
            end
            else
            begin
                want = expected_crc_q.pop_front();
                if (crc_value !== want.crc)
                begin
                    failures++;
                    $display("%0t: crc_value expected %02h actual %02h",
                             $time, want.crc, crc_value);
                end
                if (crc_final !== want.is_last)
                begin
                    failures++;
                    $display("%0t: crc_final expected %0b actual %0b",
                             $time, want.is_last, crc_final);
                end
            end
        end
    end

    // watchdog on a cycle counter
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("** datagram_crc8_generator: FAILED **");
        $finish;
    end

endmodule

@@ datagram_crc8_generator.f @@
hw/rtl/dcrc8_pkg.sv
hw/rtl/dcrc8_in_stage.sv
hw/rtl/dcrc8_fold.sv
hw/rtl/datagram_crc8_generator.sv
test/datagram_crc8_generator_test.sv
